/* hw/rtl/segment_run_collector_top_assert.svh */
// Assertion macros for the segment run collector.
// Both macros sample on clk and are disabled while rst is high.
`ifndef SEGMENT_RUN_COLLECTOR_TOP_ASSERT_SVH
`define SEGMENT_RUN_COLLECTOR_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define SRC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Consequent checked from the following cycle on
`define SRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* hw/rtl/src_pkg.sv */
package src_pkg;

  // Table geometry
  localparam int SEGMENTS    = 128;
  localparam int SEG_BYTES   = 16;
  localparam int COUNT_W     = 16;
  localparam int MAX_RUNS    = 64;
  localparam int IDX_W       = $clog2(SEGMENTS);
  localparam int SIZE_W      = 12;
  localparam int LIMIT       = SEGMENTS - 1;
  localparam int TOTAL_BYTES = SEGMENTS * SEG_BYTES;

  // Rounded segment count of one size, the walk target, and run length
  localparam int SEGS_W  = $clog2((2**SIZE_W + SEG_BYTES - 2) / SEG_BYTES + 1);
  localparam int NEXT_W  = ((IDX_W > SEGS_W) ? IDX_W : SEGS_W) + 1;
  localparam int LEN_W   = $clog2(TOTAL_BYTES + (2**SEGS_W) * SEG_BYTES) + 1;
  localparam int NRUN_W  = $clog2(MAX_RUNS + 1);

  // Action codes
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_SCAN = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [IDX_W-1:0]  segment;
    logic              received;
    logic              checksum_error;
    logic              overflow_error;
    logic [SIZE_W-1:0] size_bytes;
  } in_t;

  typedef struct packed {
    logic               run_valid;
    logic [IDX_W-1:0]   run_start;
    logic [SIZE_W-1:0]  run_bytes;
    logic [COUNT_W-1:0] checksum_count;
    logic [COUNT_W-1:0] overflow_count;
    logic               last;
  } out_t;

  // One table entry: reported size and both error counters
  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] cs;
    logic [COUNT_W-1:0] ov;
  } entry_t;

  // Saturating increment
  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    bump = (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
  endfunction

endpackage

/* hw/rtl/segment_run_collector_top.sv */
// Segment run collector: a start with busy low accepts one transaction.
// A load does a counter read-modify-write on the table memory and gives
// no result. A counter read returns one result. A scan walks segments
// 0..126, stepping past an unmarked segment and waiting at a marked one
// for its size (table memory read latency); a closing state then emits
// the final result. Runs come out one per strobe while busy is high; the
// final result (last=1) comes with busy already low. The receiver cannot
// stall: every result must be taken in the cycle its strobe is high.
module segment_run_collector_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  src_pkg::in_t item,
  output logic         strobe,
  output src_pkg::out_t result
);
  import src_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]        state;
  logic [IDX_W-1:0]  idx;
  logic              rx_mark;
  logic              cs_err;
  logic              ov_err;
  logic [SIZE_W-1:0] load_size;

  // Table memory and its per-entry written flags
  entry_t            mem [SEGMENTS];
  entry_t            rd_entry;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  entry_t            wr_entry;
  logic [SEGMENTS-1:0] cnt_valid;
  logic [SEGMENTS-1:0] marks;

  // Scan state
  logic              rd_ok;
  logic [LEN_W-1:0]  length;
  logic [IDX_W-1:0]  chain_start;
  logic              held;
  logic [IDX_W-1:0]  held_start;
  logic [LEN_W-1:0]  held_bytes;
  logic [NRUN_W-1:0] nruns;

  // Scan step arithmetic
  logic [SIZE_W:0]    size_sum;
  logic [SEGS_W-1:0]  segs;
  logic [IDX_W-1:0]   start_eff;
  logic [LEN_W-1:0]   len_new;
  logic [LEN_W-1:0]   room;
  logic [LEN_W-1:0]   len_clip;
  logic [NEXT_W-1:0]  next_idx;
  logic               at_end;
  logic [COUNT_W-1:0] cs_cur;
  logic [COUNT_W-1:0] ov_cur;

  assign busy = (state != ST_IDLE);

  // Memory port: address from the item while idle, else the working index
  assign rd_addr  = (state == ST_IDLE) ? item.segment : idx;
  assign wr_en    = (state == ST_LOAD);
  assign wr_entry = '{size: load_size,
                      cs:   cs_err ? bump(cs_cur) : cs_cur,
                      ov:   ov_err ? bump(ov_cur) : ov_cur};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

  // Counters of an entry never written read as zero
  always_comb begin
    cs_cur = cnt_valid[idx] ? rd_entry.cs : '0;
    ov_cur = cnt_valid[idx] ? rd_entry.ov : '0;
  end

  // Round size up to whole segments; zero size counts as one
  always_comb begin
    size_sum  = {1'b0, rd_entry.size} + (SIZE_W+1)'(SEG_BYTES - 1);
    segs      = SEGS_W'(size_sum / SEG_BYTES);
    if (segs == '0) begin
      segs = SEGS_W'(1);
    end
    start_eff = (length == '0) ? idx : chain_start;
    len_new   = length + LEN_W'(segs) * LEN_W'(SEG_BYTES);
    next_idx  = NEXT_W'(idx) + NEXT_W'(segs);
    at_end    = (next_idx >= NEXT_W'(LIMIT));
    room      = LEN_W'(TOTAL_BYTES) - LEN_W'(start_eff) * LEN_W'(SEG_BYTES);
    len_clip  = (len_new > room) ? room : len_new;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      strobe    <= 1'b0;
      marks     <= '0;
      cnt_valid <= '0;
      held      <= 1'b0;
      nruns     <= '0;
      rd_ok     <= 1'b0;
      length    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          strobe <= 1'b0;
          if (start) begin
            // A scan walks from segment 0
            idx       <= (item.action == ACT_SCAN) ? '0 : item.segment;
            rx_mark   <= item.received;
            cs_err    <= item.checksum_error;
            ov_err    <= item.overflow_error;
            load_size <= item.size_bytes;
            case (item.action)
              ACT_LOAD: begin
                if (item.segment < IDX_W'(LIMIT)) begin
                  state <= ST_LOAD;
                end
              end
              ACT_READ: state <= ST_READ;
              ACT_SCAN: begin
                state  <= ST_SCAN;
                rd_ok  <= 1'b0;
                length <= '0;
                held   <= 1'b0;
                nruns  <= '0;
              end
              default: ;
            endcase
          end
        end

        ST_LOAD: begin
          strobe         <= 1'b0;
          marks[idx]     <= rx_mark & ~cs_err & ~ov_err;
          cnt_valid[idx] <= 1'b1;
          state          <= ST_IDLE;
        end

        ST_READ: begin
          strobe <= 1'b1;
          result <= '{run_valid: 1'b0, run_start: '0, run_bytes: '0,
                      checksum_count: cs_cur, overflow_count: ov_cur, last: 1'b1};
          state  <= ST_IDLE;
        end

        ST_SCAN: begin
          if (!marks[idx]) begin
            // Unmarked: chain breaks, step by one
            strobe <= 1'b0;
            length <= '0;
            rd_ok  <= 1'b0;
            if (NEXT_W'(idx) + NEXT_W'(1) >= NEXT_W'(LIMIT)) begin
              state <= ST_FIN;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end else if (!rd_ok) begin
            // Wait for the size of this segment
            strobe <= 1'b0;
            rd_ok  <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            if (at_end || !marks[next_idx[IDX_W-1:0]]) begin
              // Run complete: hand out the held one, hold this one
              strobe <= held && (nruns < NRUN_W'(MAX_RUNS));
              if (nruns < NRUN_W'(MAX_RUNS)) begin
                if (held) begin
                  result <= '{run_valid: 1'b1, run_start: held_start,
                              run_bytes: held_bytes[SIZE_W-1:0],
                              checksum_count: '0, overflow_count: '0, last: 1'b0};
                end
                held       <= 1'b1;
                held_start <= start_eff;
                held_bytes <= at_end ? len_clip : len_new;
                nruns      <= nruns + NRUN_W'(1);
              end
              length <= '0;
              if (at_end) begin
                state <= ST_FIN;
              end else begin
                idx <= next_idx[IDX_W-1:0];
              end
            end else begin
              // Chain continues
              strobe      <= 1'b0;
              length      <= len_new;
              chain_start <= start_eff;
              idx         <= next_idx[IDX_W-1:0];
            end
          end
        end

        ST_FIN: begin
          strobe <= 1'b1;
          result <= '{run_valid: held, run_start: held ? held_start : '0,
                      run_bytes: held ? held_bytes[SIZE_W-1:0] : '0,
                      checksum_count: '0, overflow_count: '0, last: 1'b1};
          marks  <= '0;
          held   <= 1'b0;
          state  <= ST_IDLE;
        end

        default: begin
          strobe <= 1'b0;
          state  <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/src_checker.sv */
`include "segment_run_collector_top_assert.svh"

module src_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input src_pkg::in_t  item,
  input logic          strobe,
  input src_pkg::out_t result
);
  import src_pkg::*;

  logic acc_read;
  logic acc_load;

  assign acc_read = start && !busy && (item.action == ACT_READ);
  assign acc_load = start && !busy && (item.action == ACT_LOAD);

  // A counter read is followed by a counter result (last set, no run)
  `SRC_ASSERT_NEXT(a_read_result, acc_read, ##1 (strobe && result.last && !result.run_valid))

  // A load produces no result
  `SRC_ASSERT_NEXT(a_load_silent, acc_load, (!strobe ##1 !strobe))

  // Only the final result of a transaction may appear with busy low
  `SRC_ASSERT_SAME(a_mid_busy, (strobe && !result.last), busy)

  // A run is a nonzero whole number of segments
  `SRC_ASSERT_SAME(a_run_whole, (strobe && result.run_valid),
                   ((result.run_bytes != '0) && (result.run_bytes[3:0] == 4'd0)))

  // Nothing follows the final result directly
  `SRC_ASSERT_NEXT(a_last_gap, (strobe && result.last), !strobe)

endmodule

bind segment_run_collector_top src_checker u_src_checker (.*);

/* test/segment_run_collector_checker.sv */
`timescale 1ns / 100ps

module segment_run_collector_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  src_pkg::in_t  item,
  input  logic          strobe,
  input  src_pkg::out_t result,
  output int            fail_count,
  output int            outstanding,
  output int            results_checked
);
  import src_pkg::*;

  // Shadow copy of the receive table
  logic               rx_mark  [SEGMENTS];
  logic [SIZE_W-1:0]  seg_size [SEGMENTS];
  logic [COUNT_W-1:0] cs_tally [SEGMENTS];
  logic [COUNT_W-1:0] ov_tally [SEGMENTS];

  // Results still owed by the block, oldest first
  out_t results_due[$];
  int   mismatches = 0;
  int   n_checked  = 0;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic out_t run_result(input int unsigned first_seg, input int unsigned nbytes);
    out_t r;
    r = '0;
    r.run_valid = 1'b1;
    r.run_start = IDX_W'(first_seg);
    r.run_bytes = SIZE_W'(nbytes);
    return r;
  endfunction

  // Walk the marked segments and queue one result per run (at most MAX_RUNS), or an empty final result if none
  task automatic predict_scan();
    int unsigned idx, first_seg, run_len, nsegs, target, room, nruns;
    bit          walking;
    out_t        r;
    idx       = 0;
    first_seg = 0;
    run_len   = 0;
    nruns     = 0;
    walking   = 1'b1;
    while (walking && idx < LIMIT) begin
      if (rx_mark[idx]) begin
        nsegs = (int'(seg_size[idx]) + SEG_BYTES - 1) / SEG_BYTES;
        if (nsegs == 0) nsegs = 1;  // empty segment still occupies one slot
        if (run_len == 0) first_seg = idx;
        run_len += nsegs * SEG_BYTES;
        target = idx + nsegs;
        if (target >= LIMIT) begin
          // run hits the delay segment: clip at the buffer end and stop
          room = TOTAL_BYTES - first_seg * SEG_BYTES;
          if (run_len > room) run_len = room;
          if (nruns < MAX_RUNS) begin
            results_due.push_back(run_result(first_seg, run_len));
            nruns++;
          end
          walking = 1'b0;
        end else begin
          if (!rx_mark[target]) begin
            if (nruns < MAX_RUNS) begin
              results_due.push_back(run_result(first_seg, run_len));
              nruns++;
            end
            run_len = 0;
          end
          idx = target;
        end
      end else begin
        run_len = 0;
        idx++;
      end
    end
    for (int k = 0; k < SEGMENTS; k++) rx_mark[k] = 1'b0;
    if (nruns == 0) begin
      r = '0;
      r.last = 1'b1;
      results_due.push_back(r);
    end else begin
      r = results_due.pop_back();
      r.last = 1'b1;
      results_due.push_back(r);
    end
  endtask

  // Apply one accepted transaction to the shadow table
  task automatic predict(input in_t it);
    out_t r;
    if (it.action == ACT_LOAD) begin
      if (it.segment < LIMIT) begin
        if (it.checksum_error) cs_tally[it.segment] = sat_inc(cs_tally[it.segment]);
        if (it.overflow_error) ov_tally[it.segment] = sat_inc(ov_tally[it.segment]);
        rx_mark[it.segment]  = it.received & ~it.checksum_error & ~it.overflow_error;
        seg_size[it.segment] = it.size_bytes;
      end
    end else if (it.action == ACT_READ) begin
      r = '0;
      r.last = 1'b1;
      if (it.segment < LIMIT) begin
        r.checksum_count = cs_tally[it.segment];
        r.overflow_count = ov_tally[it.segment];
      end
      results_due.push_back(r);
    end else if (it.action == ACT_SCAN) begin
      predict_scan();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (results_due.size() == 0) begin
      $error("result with no transaction pending (start %0d, bytes %0d)",
             got.run_start, got.run_bytes);
      mismatches++;
      return;
    end
    want = results_due.pop_front();
    n_checked++;
    check_field("run_valid", want.run_valid, got.run_valid);
    check_field("run_start", want.run_start, got.run_start);
    check_field("run_bytes", want.run_bytes, got.run_bytes);
    check_field("checksum_count", want.checksum_count, got.checksum_count);
    check_field("overflow_count", want.overflow_count, got.overflow_count);
    check_field("last", want.last, got.last);
  endtask

  // Compare results, then fold in any transaction accepted at this edge
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SEGMENTS; k++) begin
        rx_mark[k]  = 1'b0;
        seg_size[k] = '0;
        cs_tally[k] = '0;
        ov_tally[k] = '0;
      end
      results_due.delete();
    end else begin
      if ($isunknown(strobe)) begin
        $error("strobe is unknown");
        mismatches++;
      end else if (strobe) begin
        check_result(result);
      end
      if (start && !busy) predict(item);
    end
    fail_count      <= mismatches;
    outstanding     <= results_due.size();
    results_checked <= n_checked;
  end

endmodule

/* test/tb_segment_run_collector_top.sv */
`timescale 1ns / 100ps

module tb_segment_run_collector_top;
  import src_pkg::*;

  // Action code the block ignores
  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         ITEM_TARGET = 180;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  item;
  logic strobe;
  out_t result;

  int fail_count;
  int outstanding;
  int results_checked;
  int n_load    = 0;
  int n_scan    = 0;
  int n_read    = 0;
  int n_ignored = 0;
  int n_items   = 0;
  bit gaps_on   = 1'b1;

  segment_run_collector_top uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  segment_run_collector_checker chk (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .item            (item),
    .strobe          (strobe),
    .result          (result),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic in_t mk(input logic [1:0] act, input int seg, input bit rx,
                             input bit cs, input bit ov, input int nbytes);
    in_t x;
    x.action         = act;
    x.segment        = IDX_W'(seg);
    x.received       = rx;
    x.checksum_error = cs;
    x.overflow_error = ov;
    x.size_bytes     = SIZE_W'(nbytes);
    return x;
  endfunction

  // Present one transaction and hold it until the block takes it
  task automatic send(input in_t x);
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= x;
    do @(posedge clk); while (busy);
    if (x.action == ACT_UNUSED || (x.action == ACT_LOAD && x.segment >= LIMIT)) begin
      n_ignored++;
    end else begin
      n_items++;
      if (x.action == ACT_LOAD) n_load++;
      else if (x.action == ACT_SCAN) n_scan++;
      else n_read++;
    end
  endtask

  function automatic in_t rand_item(input logic [1:0] act);
    return mk(act, $urandom_range(0, SEGMENTS - 1), $urandom_range(0, 1),
              $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 4095));
  endfunction

  // A burst of loads, mostly chained, closed by a scan
  task automatic burst_and_scan();
    int n, seg, nbytes, pick, nsegs;
    n   = $urandom_range(1, 12);
    seg = $urandom_range(0, LIMIT - 1);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) nbytes = $urandom_range(0, 48);
      else if (pick < 90) nbytes = $urandom_range(0, 2048);
      else nbytes = $urandom_range(0, 4095);
      send(mk(ACT_LOAD, seg, $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0,
              $urandom_range(0, 9) == 0, nbytes));
      nsegs = (nbytes + SEG_BYTES - 1) / SEG_BYTES;
      if (nsegs == 0) nsegs = 1;
      if ($urandom_range(0, 2) != 0) seg = seg + nsegs + ($urandom_range(0, 3) == 0);
      else seg = $urandom_range(0, SEGMENTS - 1);
      if (seg > SEGMENTS - 1) seg = $urandom_range(0, SEGMENTS - 1);
    end
    send(rand_item(ACT_SCAN));
  endtask

  // Every even segment marked: the scan yields the most runs possible
  task automatic alternate_fill_and_scan();
    for (int s = 0; s < LIMIT; s += 2) begin
      send(mk(ACT_LOAD, s, 1'b1, 1'b0, 1'b0, $urandom_range(0, SEG_BYTES)));
    end
    send(rand_item(ACT_SCAN));
  endtask

  initial begin
    int pick;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, zero size, chains, clipping, errors, ignored cases
    send(mk(ACT_READ, 0, 1'b0, 1'b0, 1'b0, 0));
    send(mk(ACT_READ, LIMIT, 1'b1, 1'b1, 1'b1, 4095));
    send(mk(ACT_SCAN, 0, 1'b0, 1'b0, 1'b0, 0));
    send(mk(ACT_LOAD, 0, 1'b1, 1'b0, 1'b0, 0));
    send(mk(ACT_LOAD, 1, 1'b1, 1'b0, 1'b0, 17));
    send(mk(ACT_LOAD, 5, 1'b1, 1'b0, 1'b0, 4095));
    send(mk(ACT_SCAN, 127, 1'b1, 1'b1, 1'b1, 4095));
    send(mk(ACT_LOAD, 126, 1'b1, 1'b0, 1'b0, 2048));
    send(mk(ACT_LOAD, LIMIT, 1'b1, 1'b0, 1'b0, 64));
    send(mk(ACT_UNUSED, 127, 1'b1, 1'b1, 1'b1, 4095));
    send(mk(ACT_SCAN, 0, 1'b0, 1'b0, 1'b0, 0));
    send(mk(ACT_LOAD, 10, 1'b1, 1'b1, 1'b0, 4095));
    send(mk(ACT_LOAD, 10, 1'b1, 1'b0, 1'b1, 16));
    send(mk(ACT_LOAD, 10, 1'b1, 1'b1, 1'b1, 16));
    send(mk(ACT_LOAD, LIMIT, 1'b1, 1'b1, 1'b1, 16));
    send(mk(ACT_READ, 10, 1'b0, 1'b0, 1'b0, 0));
    send(mk(ACT_READ, LIMIT, 1'b0, 1'b0, 1'b0, 0));
    send(mk(ACT_LOAD, 20, 1'b1, 1'b0, 1'b0, 16));
    send(mk(ACT_LOAD, 21, 1'b1, 1'b0, 1'b0, 1));
    send(mk(ACT_LOAD, 22, 1'b1, 1'b0, 1'b0, 0));
    send(mk(ACT_LOAD, 24, 1'b1, 1'b0, 1'b0, 15));
    send(mk(ACT_LOAD, 30, 1'b0, 1'b0, 1'b0, 32));
    send(mk(ACT_LOAD, 2, 1'b1, 1'b0, 1'b0, 2048));
    send(mk(ACT_LOAD, 2, 1'b0, 1'b0, 1'b0, 2048));
    send(mk(ACT_SCAN, 64, 1'b1, 1'b0, 1'b1, 2730));

    alternate_fill_and_scan();

    // Random mix; the sender never pauses through the middle stretch
    while (n_items < ITEM_TARGET) begin
      gaps_on = !(n_items >= 110 && n_items < 150);
      pick = $urandom_range(0, 99);
      if (pick < 55) burst_and_scan();
      else if (pick < 75) send(rand_item(ACT_READ));
      else if (pick < 90) send(rand_item(ACT_LOAD));
      else send(rand_item(2'($urandom_range(0, 3))));
    end
    start <= 1'b0;

    // Drain, then allow for a full scan's latency
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (300) @(posedge clk);

    $display("Covered %0d segment loads, %0d scans, %0d counter reads, %0d ignored transactions.",
             n_load, n_scan, n_read, n_ignored);
    $display("%0d results compared against the predicted table.", results_checked);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
